// File: hdl/vqdsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqdsm_pkg
// shared constants, codes and controller/datapath handshake types for the
// virtqueue descriptor slot manager
// ----------------------------------------------------------------------------
package vqdsm_pkg;

   // descriptor table depth and derived widths
   localparam int MAX_SLOTS = 64;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int LIMIT_W   = SLOT_W + 1;

   // external field widths
   localparam int CSR_W    = 3;
   localparam int ADDR_W   = 64;
   localparam int LEN_W    = 32;
   localparam int CNT_W    = 16;
   localparam int STATUS_W = 2;
   localparam int DESC_W   = ADDR_W + LEN_W + 1;

   // packed word widths
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 128;

   // largest usable log2 queue size
   localparam logic [CSR_W-1:0] LOG2_MAX   = CSR_W'(SLOT_W);
   localparam logic [CSR_W-1:0] LOG2_RESET = CSR_W'(6);

   // ring counter increment
   localparam logic [CNT_W-1:0] CNT_STEP = CNT_W'(1);

   // command codes carried on tuser
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic exec;   // execute the word being accepted
      logic load;   // move the pending result into the output register
   } vqdsm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // output register empty or draining this cycle
   } vqdsm_sts_type;

endpackage

// File: hdl/virtqueue_descriptor_slot_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtqueue_descriptor_slot_manager_unit
// driver side of a split virtqueue: descriptor slot allocation on enqueue,
// descriptor return and slot release on dequeue
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             contents
//  req      in         req_tvalid/tready     tuser command, tdata descriptor or used id
//  rsp      out        rsp_tvalid/tready     tdata status, slot, ring position, descriptor
//  csr      in         csr_wr_en             queue_size_log2 (3 bits)
//
//  per word: accept and execute (free-slot encode, busy bits,
//  descriptor memory write or read), then load the output register
//  the next word is accepted once the result has moved to the output register
//  a stalled output holds the result in the sequencer's load state
//  reset clears busy bits, both counters and output valid; size register to 6
//
module virtqueue_descriptor_slot_manager_unit (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [vqdsm_pkg::CSR_W-1:0]        csr_wr_data,   // queue_size_log2
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // buffer_address[63:0], buffer_length[95:64], device_writable[96], used_id[102:97]
   input  logic [vqdsm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                               req_tuser,     // command
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status[1:0], slot[7:2], ring_position[13:8], avail_index[29:14],
   // out_address[93:30], out_length[125:94], out_writable[126]
   output logic [vqdsm_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // sequencer commands and datapath status
   vqdsm_pkg::vqdsm_cmd_type cmd;
   vqdsm_pkg::vqdsm_sts_type sts;

   vqdsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // slot table, counters and output register
   vqdsm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// File: hdl/vqdsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqdsm_ctrl
// two-state sequencer: accept and execute a word, then hand its result to
// the output register
// ----------------------------------------------------------------------------
module vqdsm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output vqdsm_pkg::vqdsm_cmd_type cmd,
   input  vqdsm_pkg::vqdsm_sts_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOAD = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.exec   = 1'b0;
      cmd.load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/vqdsm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqdsm_datapath
// slot busy bits, free-slot encoder, descriptor memory, ring counters and
// the output register
// ----------------------------------------------------------------------------
module vqdsm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [vqdsm_pkg::CSR_W-1:0]         csr_wr_data,
   input  logic [vqdsm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vqdsm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  vqdsm_pkg::vqdsm_cmd_type            cmd,
   output vqdsm_pkg::vqdsm_sts_type            sts
);

   localparam int SW = vqdsm_pkg::SLOT_W;
   localparam int LW = vqdsm_pkg::LIMIT_W;

   // lowest set bit of a slot vector
   function automatic logic [SW-1:0] lowest_set(input logic [vqdsm_pkg::MAX_SLOTS-1:0] v);
      logic [SW-1:0] idx;
      idx = '0;
      for (int i = vqdsm_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SW'(i);
         end
      end
      return idx;
   endfunction

   // request fields
   logic [vqdsm_pkg::ADDR_W-1:0] req_addr;
   logic [vqdsm_pkg::LEN_W-1:0]  req_len;
   logic                         req_wr;
   logic [SW-1:0]                req_id;

   assign req_addr = req_tdata[63:0];
   assign req_len  = req_tdata[95:64];
   assign req_wr   = req_tdata[96];
   assign req_id   = req_tdata[102:97];

   // architectural state
   logic [vqdsm_pkg::CSR_W-1:0]     qlog2_ff;
   logic [vqdsm_pkg::MAX_SLOTS-1:0] busy_ff;
   logic [vqdsm_pkg::MAX_SLOTS-1:0] busy_in;
   logic [vqdsm_pkg::CNT_W-1:0]     avail_cnt_ff;
   logic [vqdsm_pkg::CNT_W-1:0]     avail_cnt_in;
   logic [vqdsm_pkg::CNT_W-1:0]     used_cnt_ff;
   logic [vqdsm_pkg::CNT_W-1:0]     used_cnt_in;
   logic [vqdsm_pkg::DESC_W-1:0]    desc_mem [vqdsm_pkg::MAX_SLOTS];

   // pending result
   logic [vqdsm_pkg::STATUS_W-1:0] pend_status_ff;
   logic [vqdsm_pkg::STATUS_W-1:0] pend_status_in;
   logic [SW-1:0]                  pend_slot_ff;
   logic [SW-1:0]                  pend_slot_in;
   logic [SW-1:0]                  pend_pos_ff;
   logic [SW-1:0]                  pend_pos_in;
   logic                           pend_deq_ff;
   logic                           pend_deq_in;
   logic [vqdsm_pkg::DESC_W-1:0]   rd_desc_ff;

   // output register
   logic                               out_valid_ff;
   logic                               out_valid_in;
   logic [vqdsm_pkg::RSP_DATA_W-1:0]   out_data_ff;
   logic [vqdsm_pkg::RSP_DATA_W-1:0]   out_data_in;

   // queue geometry
   logic [vqdsm_pkg::CSR_W-1:0]     qlog2_eff;
   logic [LW-1:0]                   limit;
   logic [LW-1:0]                   limit_m1;
   logic [SW-1:0]                   pos_mask;
   logic [vqdsm_pkg::MAX_SLOTS-1:0] in_range;
   logic [vqdsm_pkg::MAX_SLOTS-1:0] free_vec;
   logic [SW-1:0]                   free_idx;
   logic                            full;
   logic                            enq_ok;
   logic [vqdsm_pkg::DESC_W-1:0]    deq_desc;

   assign qlog2_eff = (qlog2_ff > vqdsm_pkg::LOG2_MAX) ? vqdsm_pkg::LOG2_MAX : qlog2_ff;
   assign limit     = {{SW{1'b0}}, 1'b1} << qlog2_eff;
   assign limit_m1  = limit - {{SW{1'b0}}, 1'b1};
   assign pos_mask  = limit_m1[SW-1:0];

   always_comb begin
      for (int i = 0; i < vqdsm_pkg::MAX_SLOTS; i++) begin
         in_range[i] = (LW'(i) < limit);
      end
   end

   assign free_vec = ~busy_ff & in_range;
   assign free_idx = lowest_set(free_vec);
   assign full     = (free_vec == '0);

   // execute step: checks, state updates and pending result
   always_comb begin
      busy_in        = busy_ff;
      avail_cnt_in   = avail_cnt_ff;
      used_cnt_in    = used_cnt_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_pos_in    = pend_pos_ff;
      pend_deq_in    = pend_deq_ff;
      enq_ok         = 1'b0;
      if (cmd.exec) begin
         pend_status_in = vqdsm_pkg::ST_OK;
         pend_slot_in   = '0;
         pend_pos_in    = '0;
         pend_deq_in    = 1'b0;
         if (req_tuser == vqdsm_pkg::CMD_ENQUEUE) begin
            if (full) begin
               pend_status_in = vqdsm_pkg::ST_FULL;
            end else begin
               enq_ok            = 1'b1;
               pend_slot_in      = free_idx;
               pend_pos_in       = avail_cnt_ff[SW-1:0] & pos_mask;
               busy_in[free_idx] = 1'b1;
               avail_cnt_in      = avail_cnt_ff + vqdsm_pkg::CNT_STEP;
            end
         end else begin
            if ({1'b0, req_id} >= limit) begin
               pend_status_in = vqdsm_pkg::ST_RANGE;
            end else if (!busy_ff[req_id]) begin
               pend_status_in = vqdsm_pkg::ST_EMPTY;
            end else begin
               pend_deq_in     = 1'b1;
               pend_slot_in    = req_id;
               pend_pos_in     = used_cnt_ff[SW-1:0] & pos_mask;
               busy_in[req_id] = 1'b0;
               used_cnt_in     = used_cnt_ff + vqdsm_pkg::CNT_STEP;
            end
         end
      end
   end

   // descriptor memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (enq_ok) begin
         desc_mem[free_idx] <= {req_wr, req_len, req_addr};
      end
      if (cmd.exec) begin
         rd_desc_ff <= desc_mem[req_id];
      end
   end

   // output word
   assign deq_desc = pend_deq_ff ? rd_desc_ff : '0;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load) begin
         out_valid_in = 1'b1;
         out_data_in  = {1'b0, deq_desc, avail_cnt_ff, pend_pos_ff, pend_slot_ff,
                         pend_status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlog2_ff     <= vqdsm_pkg::LOG2_RESET;
         busy_ff      <= '0;
         avail_cnt_ff <= '0;
         used_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            qlog2_ff <= csr_wr_data;
         end
         busy_ff      <= busy_in;
         avail_cnt_ff <= avail_cnt_in;
         used_cnt_ff  <= used_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      pend_pos_ff    <= pend_pos_in;
      pend_deq_ff    <= pend_deq_in;
      out_data_ff    <= out_data_in;
   end

   assign sts.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;

endmodule
